// ===== rtl/core/ocb_pkg.sv =====
// shared constants and codes for the online cluster buffer
package ocb_pkg;

  localparam int unsigned MAX_CLUSTERS = 8;
  localparam int unsigned MAX_DIMS     = 8;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned DIM_W        = 3;
  localparam int unsigned ADDR_W       = SLOT_W + DIM_W;
  localparam int unsigned DEPTH        = MAX_CLUSTERS * MAX_DIMS;
  localparam int unsigned CFG_W        = 4;
  localparam int unsigned VAL_W        = 16;
  localparam int unsigned FIT_W        = 32;
  localparam int unsigned MAG_W        = 33;
  localparam int unsigned DIV_STEPS    = 33;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_DIMS     = 2'd1;

  localparam logic ACT_IMPORT = 1'b0;
  localparam logic ACT_EXPORT = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_EXPORT = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

endpackage

// ===== rtl/core/online_cluster_buffer_core.sv =====
// online cluster buffer: streaming sequential k-means over individuals
//
// an input word either imports one coordinate (action 0) or requests an
// export (action 1). the fitness is taken with the last coordinate.
// configuration: cfg_we_i writes cluster capacity (index 0) or dims in use
// (index 1); write only while the block is idle.
// an import that does not complete an individual gives no result. a
// completing import either opens a cluster, writing its centre and
// representative, or merges into the nearest cluster: a distance walk
// over each coordinate of each open cluster, then a mean per coordinate
// from the shared multiplier and the one-bit-a-cycle restoring divider,
// then a representative write. an export walks the clusters and emits
// the coordinates of each updated cluster, one word each.
// in_stall_o stays high while an item is being worked on. results leave
// through one output register; a stalled receiver holds that word and
// the sequencer waits for the register to free up. a new item is taken
// while the last result still waits. reset clears the staging count,
// open clusters and updated flags; stores are written before they are read.
module online_cluster_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic signed [15:0] element_value_i,
  input  logic signed [31:0] fitness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [2:0]  slot_o,
  output logic        created_o,
  output logic [2:0]  element_index_o,
  output logic signed [15:0] out_value_o,
  output logic signed [31:0] out_fitness_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WR_SWEEP, ST_DI_RD, ST_DI_SQ, ST_DI_ACC, ST_MN_RD, ST_MN_MUL,
    ST_MN_ADD, ST_MN_DIV, ST_MN_WB, ST_FIN, ST_REPORT, ST_EX_SCAN, ST_EX_RD,
    ST_EX_OUT
  } state_e;

  state_e state_q;

  logic [3:0]  cap_q, dims_q, cnt_q, open_q, c_q;
  logic [2:0]  i_q, best_q;
  logic [7:0]  flag_q;
  logic        creating_q;
  logic [35:0] sum_q, best_sum_q;
  logic signed [35:0] prod_q;
  logic [32:0] dv_q;
  logic [16:0] rem_q, den_q;
  logic        neg_q;
  logic [5:0]  step_q;
  logic [31:0] fit_q;

  logic [15:0] stage_q [ocb_pkg::MAX_DIMS];
  logic [15:0] count_q [ocb_pkg::MAX_CLUSTERS];
  logic [31:0] rfit_q  [ocb_pkg::MAX_CLUSTERS];

  logic        out_valid_q, kind_q, created_q, last_q;
  logic [2:0]  slot_q, eidx_q;
  logic [15:0] oval_q;
  logic [31:0] ofit_q;

  logic [3:0]  cap, dims;
  logic        in_acc, out_free, out_load, last_dim, more_flagged;
  logic [3:0]  cnt_inc;
  logic [ocb_pkg::ADDR_W-1:0] ram_addr;
  logic [15:0] cen_rd, rep_rd, stage_cur, sweep_val, cen_wdata;
  logic        cen_we, rep_we;
  logic signed [16:0] diff;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p, num;
  logic [35:0] mag;
  logic [17:0] rem_sh;
  logic [32:0] quot;
  logic [15:0] cnt_cur;

  always_comb begin
    if (cap_q == 4'd0) begin
      cap = 4'd1;
    end else if (cap_q > 4'(ocb_pkg::MAX_CLUSTERS)) begin
      cap = 4'(ocb_pkg::MAX_CLUSTERS);
    end else begin
      cap = cap_q;
    end
    if (dims_q == 4'd0) begin
      dims = 4'd1;
    end else if (dims_q > 4'(ocb_pkg::MAX_DIMS)) begin
      dims = 4'(ocb_pkg::MAX_DIMS);
    end else begin
      dims = dims_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && (state_q == ST_REPORT || state_q == ST_EX_OUT);
  assign cnt_inc    = cnt_q + 4'd1;
  assign last_dim   = ({1'b0, i_q} == dims - 4'd1);
  assign ram_addr   = {c_q[2:0], i_q};
  assign stage_cur  = stage_q[i_q];
  assign cnt_cur    = count_q[c_q[2:0]];
  assign sweep_val  = ({1'b0, i_q} < dims) ? stage_cur : 16'd0;

  always_comb begin
    more_flagged = 1'b0;
    for (int j = 0; j < ocb_pkg::MAX_CLUSTERS; j++) begin
      if (4'(j) > c_q && 4'(j) < open_q && flag_q[j]) begin
        more_flagged = 1'b1;
      end
    end
  end

  // shared multiplier: squares differences, then scales centres by count
  assign diff = 17'($signed(stage_cur)) - 17'($signed(cen_rd));
  always_comb begin
    if (state_q == ST_DI_SQ) begin
      mul_a = 18'(diff);
      mul_b = 18'(diff);
    end else begin
      mul_a = $signed({2'b00, cnt_cur});
      mul_b = 18'($signed(cen_rd));
    end
  end
  assign mul_p = mul_a * mul_b;

  assign num    = prod_q + 36'($signed(stage_cur));
  assign mag    = num[35] ? 36'(-num) : num;
  assign rem_sh = {rem_q, dv_q[32]};
  assign quot   = neg_q ? 33'(-dv_q) : dv_q;

  always_comb begin
    cen_we    = 1'b0;
    rep_we    = 1'b0;
    cen_wdata = sweep_val;
    unique case (state_q)
      ST_WR_SWEEP: begin
        cen_we = creating_q;
        rep_we = 1'b1;
      end
      ST_MN_WB: begin
        cen_we    = 1'b1;
        cen_wdata = quot[15:0];
      end
      default: ;
    endcase
  end

  ocb_ram #(.WIDTH(ocb_pkg::VAL_W), .DEPTH(ocb_pkg::DEPTH)) u_centre_ram (
    .clk_i  (clk_i),
    .we_i   (cen_we),
    .waddr_i(ram_addr),
    .wdata_i(cen_wdata),
    .raddr_i(ram_addr),
    .rdata_o(cen_rd)
  );

  ocb_ram #(.WIDTH(ocb_pkg::VAL_W), .DEPTH(ocb_pkg::DEPTH)) u_rep_ram (
    .clk_i  (clk_i),
    .we_i   (rep_we),
    .waddr_i(ram_addr),
    .wdata_i(sweep_val),
    .raddr_i(ram_addr),
    .rdata_o(rep_rd)
  );

  // datapath storage, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ocb_pkg::ACT_IMPORT) begin
      if (cnt_q < 4'(ocb_pkg::MAX_DIMS)) begin
        stage_q[cnt_q[2:0]] <= element_value_i;
      end
      fit_q <= fitness_i;
    end
    if (state_q == ST_FIN) begin
      rfit_q[c_q[2:0]] <= fit_q;
      if (creating_q) begin
        count_q[c_q[2:0]] <= 16'd1;
      end else if (cnt_cur != ocb_pkg::COUNT_MAX) begin
        count_q[c_q[2:0]] <= cnt_cur + 16'd1;
      end
    end
    unique case (state_q)
      ST_DI_SQ:  prod_q <= mul_p;
      ST_MN_MUL: prod_q <= mul_p;
      ST_MN_ADD: begin
        neg_q  <= num[35];
        dv_q   <= mag[32:0];
        rem_q  <= '0;
        den_q  <= {1'b0, cnt_cur} + 17'd1;
        step_q <= '0;
      end
      ST_MN_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= 17'(rem_sh - {1'b0, den_q});
          dv_q  <= {dv_q[31:0], 1'b1};
        end else begin
          rem_q <= rem_sh[16:0];
          dv_q  <= {dv_q[31:0], 1'b0};
        end
        step_q <= step_q + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= 4'(ocb_pkg::MAX_CLUSTERS);
      dims_q      <= 4'(ocb_pkg::MAX_DIMS);
      cnt_q       <= '0;
      open_q      <= '0;
      flag_q      <= '0;
      c_q         <= '0;
      i_q         <= '0;
      best_q      <= '0;
      creating_q  <= 1'b0;
      sum_q       <= '0;
      best_sum_q  <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      created_q   <= 1'b0;
      last_q      <= 1'b0;
      slot_q      <= '0;
      eidx_q      <= '0;
      oval_q      <= '0;
      ofit_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ocb_pkg::REG_CAPACITY: cap_q  <= cfg_data_i;
          ocb_pkg::REG_DIMS:     dims_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (action_i == ocb_pkg::ACT_EXPORT) begin
              c_q     <= '0;
              state_q <= ST_EX_SCAN;
            end else if (cnt_inc < dims) begin
              cnt_q <= cnt_inc;
            end else begin
              cnt_q <= '0;
              i_q   <= '0;
              if (open_q < cap) begin
                creating_q <= 1'b1;
                c_q        <= open_q;
                state_q    <= ST_WR_SWEEP;
              end else begin
                creating_q <= 1'b0;
                c_q        <= '0;
                sum_q      <= '0;
                state_q    <= ST_DI_RD;
              end
            end
          end
        end
        ST_WR_SWEEP: begin
          i_q <= i_q + 3'd1;
          if (i_q == 3'(ocb_pkg::MAX_DIMS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_DI_RD:  state_q <= ST_DI_SQ;
        ST_DI_SQ:  state_q <= ST_DI_ACC;
        ST_DI_ACC: begin
          if (last_dim) begin
            if (c_q == 4'd0 || (sum_q + 36'(unsigned'(prod_q))) < best_sum_q) begin
              best_q     <= c_q[2:0];
              best_sum_q <= sum_q + 36'(unsigned'(prod_q));
            end
            sum_q <= '0;
            i_q   <= '0;
            if (c_q + 4'd1 < open_q) begin
              c_q     <= c_q + 4'd1;
              state_q <= ST_DI_RD;
            end else begin
              state_q <= ST_MN_RD;
            end
          end else begin
            sum_q   <= sum_q + 36'(unsigned'(prod_q));
            i_q     <= i_q + 3'd1;
            state_q <= ST_DI_RD;
          end
          if (last_dim && !(c_q + 4'd1 < open_q)) begin
            if (c_q == 4'd0 || (sum_q + 36'(unsigned'(prod_q))) < best_sum_q) begin
              c_q <= c_q;
            end else begin
              c_q <= {1'b0, best_q};
            end
          end
        end
        ST_MN_RD:  state_q <= ST_MN_MUL;
        ST_MN_MUL: state_q <= ST_MN_ADD;
        ST_MN_ADD: state_q <= ST_MN_DIV;
        ST_MN_DIV: begin
          if (step_q == 6'(ocb_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_MN_WB;
          end
        end
        ST_MN_WB: begin
          if (last_dim) begin
            i_q     <= '0;
            state_q <= ST_WR_SWEEP;
          end else begin
            i_q     <= i_q + 3'd1;
            state_q <= ST_MN_RD;
          end
        end
        ST_FIN: begin
          flag_q[c_q[2:0]] <= 1'b1;
          if (creating_q) begin
            open_q <= open_q + 4'd1;
          end
          state_q <= ST_REPORT;
        end
        ST_REPORT: begin
          if (out_free) begin
            kind_q      <= ocb_pkg::KIND_REPORT;
            slot_q      <= c_q[2:0];
            created_q   <= creating_q;
            eidx_q      <= '0;
            oval_q      <= '0;
            ofit_q      <= '0;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_EX_SCAN: begin
          i_q <= '0;
          if (c_q >= open_q) begin
            state_q <= ST_IDLE;
          end else if (flag_q[c_q[2:0]]) begin
            state_q <= ST_EX_RD;
          end else begin
            c_q <= c_q + 4'd1;
          end
        end
        ST_EX_RD: state_q <= ST_EX_OUT;
        ST_EX_OUT: begin
          if (out_free) begin
            kind_q      <= ocb_pkg::KIND_EXPORT;
            slot_q      <= c_q[2:0];
            created_q   <= 1'b0;
            eidx_q      <= i_q;
            oval_q      <= rep_rd;
            ofit_q      <= rfit_q[c_q[2:0]];
            last_q      <= last_dim && !more_flagged;
            if (last_dim) begin
              flag_q[c_q[2:0]] <= 1'b0;
              c_q              <= c_q + 4'd1;
              state_q          <= ST_EX_SCAN;
            end else begin
              i_q     <= i_q + 3'd1;
              state_q <= ST_EX_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign slot_o          = slot_q;
  assign created_o       = created_q;
  assign element_index_o = eidx_q;
  assign out_value_o     = oval_q;
  assign out_fitness_o   = ofit_q;
  assign last_o          = last_q;

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'(ocb_pkg::MAX_CLUSTERS))
    else $error("open cluster count out of range");

  a_mean_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MN_RD) |-> (c_q < open_q))
    else $error("mean update on a cluster that is not open");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == ocb_pkg::KIND_REPORT) |-> last_o)
    else $error("placement report without last");

  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 4'(ocb_pkg::MAX_DIMS))
    else $error("staging count out of range");

endmodule

// ===== rtl/core/ocb_ram.sv =====
// generic single write port ram with registered read
module ocb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/tb_online_cluster_buffer_core.sv =====
// testbench for the online cluster buffer core with a scoreboard predicting k-means results
`timescale 1ns / 100ps

module tb_online_cluster_buffer_core;

  typedef struct {
    logic              kind;
    logic [2:0]        slot;
    logic              created;
    logic [2:0]        element_index;
    logic signed [15:0] value;
    logic signed [31:0] fitness;
    logic              last;
  } cluster_word_t;

  class cluster_scoreboard;
    logic signed [15:0] staged[ocb_pkg::MAX_DIMS];
    int unsigned        staged_cnt;
    logic signed [15:0] centre[ocb_pkg::MAX_CLUSTERS][ocb_pkg::MAX_DIMS];
    logic signed [15:0] rep_elem[ocb_pkg::MAX_CLUSTERS][ocb_pkg::MAX_DIMS];
    logic signed [31:0] rep_fit[ocb_pkg::MAX_CLUSTERS];
    int unsigned        members[ocb_pkg::MAX_CLUSTERS];
    bit                 flagged[ocb_pkg::MAX_CLUSTERS];
    int unsigned        open_cnt;
    int unsigned        capacity_reg;
    int unsigned        dims_reg;
    cluster_word_t      pending_q[$];
    int unsigned        mismatches;

    function new();
      staged_cnt   = 0;
      open_cnt     = 0;
      capacity_reg = 8;
      dims_reg     = 8;
      mismatches   = 0;
      foreach (flagged[c]) flagged[c] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      if (idx == ocb_pkg::REG_CAPACITY) capacity_reg = data;
      else if (idx == ocb_pkg::REG_DIMS) dims_reg = data;
    endfunction

    function void push_word(logic kind, int unsigned slot, logic created, int unsigned eidx,
                            logic signed [15:0] v, logic signed [31:0] f, logic last);
      cluster_word_t w;
      w.kind = kind;
      w.slot = slot[2:0];
      w.created = created;
      w.element_index = eidx[2:0];
      w.value = v;
      w.fitness = f;
      w.last = last;
      pending_q = {pending_q, w};
    endfunction

    function void note_input(logic act, logic signed [15:0] v, logic signed [31:0] f);
      int unsigned d, cap, c, best, k;
      longint unsigned sq_sum, best_dist;
      longint n, num, diff;
      d   = (dims_reg < 1) ? 1 :
            (dims_reg > ocb_pkg::MAX_DIMS) ? ocb_pkg::MAX_DIMS : dims_reg;
      cap = (capacity_reg < 1) ? 1 :
            (capacity_reg > ocb_pkg::MAX_CLUSTERS) ? ocb_pkg::MAX_CLUSTERS : capacity_reg;
      if (act == ocb_pkg::ACT_IMPORT) begin
        if (staged_cnt < ocb_pkg::MAX_DIMS) staged[staged_cnt] = v;
        staged_cnt++;
        if (staged_cnt < d) return;
        staged_cnt = 0;
        if (open_cnt < cap) begin
          c = open_cnt;
          for (int i = 0; i < ocb_pkg::MAX_DIMS; i++) begin
            centre[c][i]   = (i < d) ? staged[i] : 16'sd0;
            rep_elem[c][i] = centre[c][i];
          end
          rep_fit[c] = f;
          members[c] = 1;
          flagged[c] = 1;
          open_cnt++;
          push_word(ocb_pkg::KIND_REPORT, c, 1'b1, 0, 0, 0, 1'b1);
          return;
        end
        best = 0;
        best_dist = 0;
        for (c = 0; c < open_cnt; c++) begin
          sq_sum = 0;
          for (int i = 0; i < d; i++) begin
            diff = longint'(staged[i]) - longint'(centre[c][i]);
            sq_sum += longint'(diff * diff);
          end
          if (c == 0 || sq_sum < best_dist) begin
            best = c;
            best_dist = sq_sum;
          end
        end
        n = members[best];
        for (int i = 0; i < d; i++) begin
          num = n * longint'(centre[best][i]) + longint'(staged[i]);
          centre[best][i] = 16'(num / (n + 1));
        end
        for (int i = 0; i < ocb_pkg::MAX_DIMS; i++)
          rep_elem[best][i] = (i < d) ? staged[i] : 16'sd0;
        if (members[best] < 65535) members[best]++;
        rep_fit[best] = f;
        flagged[best] = 1;
        push_word(ocb_pkg::KIND_REPORT, best, 1'b0, 0, 0, 0, 1'b1);
      end else begin
        k = 0;
        for (c = 0; c < open_cnt; c++) begin
          if (!flagged[c]) continue;
          if (k + d > 64) break;
          for (int i = 0; i < d; i++) begin
            push_word(ocb_pkg::KIND_EXPORT, c, 1'b0, i, rep_elem[c][i], rep_fit[c], 1'b0);
            k++;
          end
          flagged[c] = 0;
        end
        if (k > 0) pending_q[pending_q.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(cluster_word_t got);
      cluster_word_t exp_w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d slot %0d", got.kind, got.slot);
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.kind !== exp_w.kind || got.slot !== exp_w.slot || got.created !== exp_w.created ||
          got.element_index !== exp_w.element_index || got.value !== exp_w.value ||
          got.fitness !== exp_w.fitness || got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp k%0d s%0d c%0d e%0d v%0d f%0d l%0d",
                    " got k%0d s%0d c%0d e%0d v%0d f%0d l%0d"},
                   exp_w.kind, exp_w.slot, exp_w.created, exp_w.element_index, exp_w.value,
                   exp_w.fitness, exp_w.last, got.kind, got.slot, got.created,
                   got.element_index, got.value, got.fitness, got.last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = ocb_pkg::REG_CAPACITY;
  logic [3:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = ocb_pkg::ACT_IMPORT;
  logic signed [15:0] element_value_i = '0;
  logic signed [31:0] fitness_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic [2:0]         slot_o;
  logic               created_o;
  logic [2:0]         element_index_o;
  logic signed [15:0] out_value_o;
  logic signed [31:0] out_fitness_o;
  logic               last_o;

  cluster_scoreboard sb = new();
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       long_hold_req = 0;
  int unsigned       hold_left = 0;
  int unsigned       words_sent = 0;
  logic signed [15:0] proto[4];

  online_cluster_buffer_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_req != 0) begin
      hold_left = long_hold_req;
      long_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    cluster_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      w.kind = kind_o;
      w.slot = slot_o;
      w.created = created_o;
      w.element_index = element_index_o;
      w.value = out_value_o;
      w.fitness = out_fitness_o;
      w.last = last_o;
      sb.check_result(w);
    end
  end

  task automatic send_word(logic act, logic signed [15:0] v, logic signed [31:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    element_value_i <= v;
    fitness_i       <= f;
    do @(negedge clk_i); while (in_stall_o);
    sb.note_input(act, v, f);
    words_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [3:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic send_individual(int unsigned d);
    int unsigned p;
    bit          wild;
    logic signed [15:0] v;
    p = $urandom_range(3);
    wild = ($urandom_range(4) == 0);
    for (int i = 0; i < d; i++) begin
      v = wild ? 16'($urandom) : proto[p] + 16'($urandom_range(512)) - 16'sd256;
      send_word(ocb_pkg::ACT_IMPORT, v, 32'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned n_words, bit pressure);
    int unsigned start, d;
    start = words_sent;
    if (pressure) long_hold_req = 400;
    while (words_sent - start < n_words) begin
      d = (sb.dims_reg < 1) ? 1 :
          (sb.dims_reg > ocb_pkg::MAX_DIMS) ? ocb_pkg::MAX_DIMS : sb.dims_reg;
      case ($urandom_range(9))
        0: send_word(ocb_pkg::ACT_EXPORT, 16'($urandom), 32'($urandom));
        1: send_word(ocb_pkg::ACT_IMPORT, 16'($urandom), 32'($urandom));
        default: begin
          send_individual(d);
          if ($urandom_range(3) == 0)
            send_word(ocb_pkg::ACT_EXPORT, 16'($urandom), 32'($urandom));
        end
      endcase
      if (pressure && words_sent - start > n_words / 2 && words_sent - start <= n_words / 2 + d)
        drain();
    end
    send_word(ocb_pkg::ACT_EXPORT, 16'sd0, 32'sd0);
    drain();
  endtask

  initial begin
    foreach (proto[i]) proto[i] = 16'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(ocb_pkg::REG_CAPACITY, 4'd2);
    write_cfg(ocb_pkg::REG_DIMS, 4'd3);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh7fff, 32'sh7fffffff);
    send_word(ocb_pkg::ACT_IMPORT, -16'sh8000, 32'sh7fffffff);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0000, 32'sh7fffffff);
    send_word(ocb_pkg::ACT_IMPORT, -16'sh8000, -32'sh80000000);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh7fff, -32'sh80000000);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0001, -32'sh80000000);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh7fff, 32'sd5);
    send_word(ocb_pkg::ACT_IMPORT, -16'sh8000, 32'sd5);
    send_word(ocb_pkg::ACT_IMPORT, -16'sh0001, 32'sd5);
    send_word(ocb_pkg::ACT_EXPORT, 16'sh0000, 32'sd0);
    send_word(ocb_pkg::ACT_EXPORT, 16'shffff, -32'sd1);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0100, 32'sd7);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0200, 32'sd8);
    drain();
    // lower dims with two coordinates already staged
    write_cfg(ocb_pkg::REG_DIMS, 4'd1);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0300, 32'sd9);
    drain();
    // capacity below the open count
    write_cfg(ocb_pkg::REG_CAPACITY, 4'd1);
    write_cfg(ocb_pkg::REG_DIMS, 4'd3);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0000, 32'sd1);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0000, 32'sd1);
    send_word(ocb_pkg::ACT_IMPORT, 16'sh0000, 32'sd1);
    send_word(ocb_pkg::ACT_EXPORT, 16'sh0000, 32'sd0);
    drain();

    write_cfg(ocb_pkg::REG_CAPACITY, 4'd15);
    write_cfg(ocb_pkg::REG_DIMS, 4'd15);
    random_phase(40, 1'b0);

    send_idle_pct = 85;
    write_cfg(ocb_pkg::REG_CAPACITY, 4'd0);
    write_cfg(ocb_pkg::REG_DIMS, 4'd0);
    random_phase(30, 1'b0);

    send_idle_pct = 0;
    recv_stall_pct = 85;
    write_cfg(ocb_pkg::REG_CAPACITY, 4'd3);
    write_cfg(ocb_pkg::REG_DIMS, 4'd5);
    random_phase(40, 1'b0);

    send_idle_pct = 21;
    recv_stall_pct = 21;
    write_cfg(ocb_pkg::REG_CAPACITY, 4'd8);
    write_cfg(ocb_pkg::REG_DIMS, 4'd2);
    random_phase(40, 1'b0);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_cfg(ocb_pkg::REG_CAPACITY, 4'd4);
    write_cfg(ocb_pkg::REG_DIMS, 4'd8);
    random_phase(50, 1'b1);

    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
